// ===== design/priority_list_arbiter_macros.svh =====
// Assertion macros for the priority list arbiter checker.
// Clocked on clk, disabled while rst_n is low; no other dependencies.
`ifndef PRIORITY_LIST_ARBITER_MACROS_SVH
`define PRIORITY_LIST_ARBITER_MACROS_SVH

// same-cycle implication
`define PLA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: lbl failed");

// next-cycle implication
`define PLA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: lbl failed");

`endif

// ===== design/pla_pkg.sv =====
// Shared types and constants for the priority list arbiter.
// No dependencies; imported by every module of the block.
package pla_pkg;

  localparam int NUM_CLASSES    = 8;
  localparam int NUM_REQUESTERS = 8;
  localparam int CLASS_W        = 3;
  localparam int ID_W           = 3;
  localparam int POS_W          = $clog2(NUM_CLASSES);
  localparam int MASK_W         = 8;
  localparam int MAP_W          = NUM_REQUESTERS * CLASS_W;

  localparam logic [MAP_W-1:0] MAP_RESET = 24'hFAC688;

  typedef logic [CLASS_W-1:0] class_t;
  typedef class_t [NUM_CLASSES-1:0] order_t;

  typedef struct packed {
    logic [MASK_W-1:0] request_mask;
    logic              update_order;
  } in_item_t;

  typedef struct packed {
    logic            grant_valid;
    logic [ID_W-1:0] grant_id;
  } out_item_t;

  function automatic order_t order_reset();
    order_t o;
    for (int p = 0; p < NUM_CLASSES; p++) begin
      o[p] = CLASS_W'(p);
    end
    return o;
  endfunction

endpackage

// ===== design/priority_list_arbiter.sv =====
// Top level of the least-recently-granted arbiter with class mapping.
// Depends on pla_pkg and pla_pick.
//
//   channel | ports                        | payload
//   in      | in_valid, in_ready, in_data  | in_item_t
//   out     | out_valid, out_ready, out_data | out_item_t
//   cfg     | cfg_we, cfg_wdata            | class map, 24 bits
//
// One transfer per cycle while the result is not stalled: input register, one pass of pick logic, result register.
// The result becomes valid when the item moves into the result register, which a stalled result
// delays; the priority list is updated on the edge the item moves into the result register.
// Reset: empty stages, identity class map, classes in ascending order.
// A stalled result holds the input stage; in_ready drops only then.
module priority_list_arbiter import pla_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_item_t        out_data,
  input  logic             cfg_we,
  input  logic [MAP_W-1:0] cfg_wdata
);

  logic             in_valid_r;
  in_item_t         in_data_r;
  logic             out_valid_r;
  out_item_t        out_data_r;
  logic [MAP_W-1:0] class_map_r;
  order_t           order_r;
  order_t           order_nxt;
  out_item_t        result;
  logic             advance;

  assign advance  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;

  pla_pick u_pick (
    .item      (in_data_r),
    .class_map (class_map_r),
    .order     (order_r),
    .result    (result),
    .order_nxt (order_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      class_map_r <= MAP_RESET;
      order_r     <= order_reset();
    end else begin
      if (cfg_we) begin
        class_map_r <= cfg_wdata;
      end
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        order_r     <= order_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_data_r <= in_data;
    end
    if (advance) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== design/pla_pick.sv =====
// Arbitration logic: winner selection over the class priority list and
// the list for the next transfer, rotated only on a grant with update_order set. Depends on pla_pkg.
module pla_pick import pla_pkg::*; (
  input  in_item_t         item,
  input  logic [MAP_W-1:0] class_map,
  input  order_t           order,
  output out_item_t        result,
  output order_t           order_nxt
);

  logic [NUM_CLASSES-1:0][NUM_REQUESTERS-1:0] class_req;
  logic [NUM_CLASSES-1:0]                     pos_hit;
  logic                                       hit;
  logic [POS_W-1:0]                           win_pos;
  class_t                                     win_class;
  logic [NUM_REQUESTERS-1:0]                  win_req;
  logic [ID_W-1:0]                            win_id;

  always_comb begin
    for (int c = 0; c < NUM_CLASSES; c++) begin
      for (int i = 0; i < NUM_REQUESTERS; i++) begin
        class_req[c][i] = item.request_mask[i] &&
                          (class_map[i*CLASS_W +: CLASS_W] == CLASS_W'(c));
      end
    end
  end

  always_comb begin
    hit     = 1'b0;
    win_pos = '0;
    for (int p = 0; p < NUM_CLASSES; p++) begin
      pos_hit[p] = |class_req[order[p]];
    end
    for (int p = NUM_CLASSES - 1; p >= 0; p--) begin
      if (pos_hit[p]) begin
        hit     = 1'b1;
        win_pos = POS_W'(p);
      end
    end
  end

  assign win_class = order[win_pos];
  assign win_req   = class_req[win_class];

  always_comb begin
    win_id = '0;
    for (int i = NUM_REQUESTERS - 1; i >= 0; i--) begin
      if (win_req[i]) begin
        win_id = ID_W'(i);
      end
    end
  end

  always_comb begin
    for (int p = 0; p < NUM_CLASSES; p++) begin
      if (hit && item.update_order && (POS_W'(p) >= win_pos)) begin
        if (p == NUM_CLASSES - 1) begin
          order_nxt[p] = win_class;
        end else begin
          order_nxt[p] = order[(p + 1) % NUM_CLASSES];
        end
      end else begin
        order_nxt[p] = order[p];
      end
    end
  end

  assign result.grant_valid = hit;
  assign result.grant_id    = hit ? win_id : '0;

endmodule

// ===== design/pla_checker.sv =====
// Port-level checker for the priority list arbiter, bound to the top level.
// Depends on pla_pkg and priority_list_arbiter_macros.svh.
`include "priority_list_arbiter_macros.svh"

module pla_checker import pla_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  `PLA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))
  `PLA_ASSERT_NOW(a_no_grant_zero, out_valid && !out_data.grant_valid, out_data.grant_id == '0)
  `PLA_ASSERT_NOW(a_stall_only_on_back, !in_ready, out_valid && !out_ready)
  `PLA_ASSERT_NEXT(a_no_out_empty, !out_valid && !(in_valid && in_ready), !out_valid || in_ready)

endmodule

bind priority_list_arbiter pla_checker u_pla_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
